[hw/rtl/pps_pkg.sv]
package pps_pkg;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_ZERO_BURST = 3'd2,
        ST_IDLE_TICK  = 3'd3,
        ST_RAN        = 3'd4,
        ST_DONE       = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_TICK_SCAN,
        S_TICK_DRAIN,
        S_TICK_FINISH,
        S_RESULT
    } state_t;

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic [15:0] TIME_MAX  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // one job table entry as stored in memory
    typedef struct packed {
        logic [15:0] remaining;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] arrival;
    } job_t;

    localparam int JOB_W = $bits(job_t);

    // request from the sequencer to the time and statistics unit
    typedef struct packed {
        logic        advance;
        logic        complete;
        logic [15:0] arrival;
        logic [15:0] burst;
    } stat_req_t;

    typedef struct packed {
        logic [15:0] cur_time;
        logic [15:0] completion;
        logic [15:0] turnaround;
        logic [15:0] waiting;
        logic [31:0] sum_turnaround;
        logic [31:0] sum_waiting;
        logic [15:0] jobs_done;
    } stat_t;

endpackage

[hw/rtl/pps_ram.sv]
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pps_stats.sv]
module pps_stats (
    input  logic                clk,
    input  logic                rst_n,
    input  pps_pkg::stat_req_t  req,
    output pps_pkg::stat_t      stat
);

    logic [15:0] time_reg;
    logic [31:0] sum_tat_reg;
    logic [31:0] sum_wt_reg;
    logic [15:0] done_reg;
    logic [15:0] ct_reg;
    logic [15:0] tat_reg;
    logic [15:0] wt_reg;

    logic [15:0] time_next;
    logic [15:0] tat_next;
    logic [15:0] wt_next;

    always_comb
    begin
        time_next = time_reg;
        if (req.advance && time_reg != pps_pkg::TIME_MAX)
        begin
            time_next = time_reg + 16'd1;
        end
        // arrival never exceeds the time at which the job ran
        tat_next = time_next - req.arrival;
        // below zero only once time has saturated
        wt_next = (tat_next >= req.burst) ? (tat_next - req.burst) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg    <= '0;
            sum_tat_reg <= '0;
            sum_wt_reg  <= '0;
            done_reg    <= '0;
        end
        else
        begin
            time_reg <= time_next;
            if (req.complete)
            begin
                sum_tat_reg <= sum_tat_reg + {16'd0, tat_next};
                sum_wt_reg  <= sum_wt_reg + {16'd0, wt_next};
                if (done_reg != pps_pkg::COUNT_MAX)
                begin
                    done_reg <= done_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.complete)
        begin
            ct_reg  <= time_next;
            tat_reg <= tat_next;
            wt_reg  <= wt_next;
        end
    end

    assign stat.cur_time       = time_reg;
    assign stat.completion     = ct_reg;
    assign stat.turnaround     = tat_reg;
    assign stat.waiting        = wt_reg;
    assign stat.sum_turnaround = sum_tat_reg;
    assign stat.sum_waiting    = sum_wt_reg;
    assign stat.jobs_done      = done_reg;

endmodule

[hw/rtl/preemptive_priority_scheduler.sv]
// add: a zero burst goes from the idle state straight to the result state; any other burst
//   walks the slot valid bits in the add scan up to the first free slot or the last slot
// tick: passes through the tick scan, drain and finish states to the result state; the scan is paced
//   by the job memory read port, which delivers one slot per cycle to the compare
// one item is worked at a time; the next input is taken while the result waits in the output
// reset (async, active low) clears valid bits, time, totals and count; job memory is not cleared
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // arrival_time, burst_length, job_priority
    input  logic         s_axis_tuser,  // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot, completion_time, turnaround_time, waiting_time, total_turnaround,
    // total_waiting, jobs_done, 4 bits zero
    output logic [135:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser   // status
);

    localparam int IDX_W = $clog2(MAX_PROCS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

    pps_pkg::state_t    state_reg;
    pps_pkg::state_t    state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [MAX_PROCS-1:0] valid_reg;
    logic [15:0]        in_arrival_reg;
    logic [15:0]        in_burst_reg;
    logic [7:0]         in_prio_reg;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    pps_pkg::job_t      best_job_reg;
    pps_pkg::status_t   res_status_reg;
    logic [IDX_W-1:0]   res_slot_reg;
    logic               out_valid_reg;
    logic [135:0]       out_tdata_reg;
    logic [2:0]         out_tuser_reg;

    logic               s_accept;
    logic               out_free;
    logic               load_out;
    logic               in_zero_burst;
    logic               slot_free;
    logic               is_last;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    pps_pkg::job_t      ram_wdata;
    logic               ram_re;
    pps_pkg::job_t      rd_job;
    logic               rd_ready;
    logic               rd_better;
    logic               job_complete;
    pps_pkg::job_t      new_job;
    pps_pkg::job_t      run_job;
    pps_pkg::stat_req_t stat_req;
    pps_pkg::stat_t     stat;
    logic [IDX_W+3:0]   slot_ext;
    logic               res_done;

    pps_ram #(
        .WIDTH (pps_pkg::JOB_W),
        .DEPTH (MAX_PROCS)
    ) u_job_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (rd_job)
    );

    pps_stats u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (stat_req),
        .stat  (stat)
    );

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_zero_burst = (s_axis_tdata[31:16] == 16'd0);
    assign slot_free     = !valid_reg[idx_reg];
    assign is_last       = (idx_reg == LAST_IDX);

    // candidate check on the entry that the memory returns this cycle
    assign rd_ready  = valid_reg[rd_idx_reg] && (rd_job.arrival <= stat.cur_time)
                       && (rd_job.remaining != 16'd0);
    assign rd_better = rd_pend_reg && rd_ready
                       && (!found_reg || (rd_job.prio < best_job_reg.prio));

    assign job_complete = found_reg && (best_job_reg.remaining == 16'd1);

    always_comb
    begin
        new_job.arrival   = in_arrival_reg;
        new_job.burst     = in_burst_reg;
        new_job.prio      = in_prio_reg;
        new_job.remaining = in_burst_reg;
        run_job           = best_job_reg;
        run_job.remaining = best_job_reg.remaining - 16'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == pps_pkg::FUNC_TICK)
                    begin
                        state_next = pps_pkg::S_TICK_SCAN;
                    end
                    else if (in_zero_burst)
                    begin
                        state_next = pps_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = pps_pkg::S_ADD_SCAN;
                    end
                end
            end
            pps_pkg::S_ADD_SCAN:
            begin
                if (slot_free || is_last)
                begin
                    state_next = pps_pkg::S_RESULT;
                end
            end
            pps_pkg::S_TICK_SCAN:
            begin
                if (is_last)
                begin
                    state_next = pps_pkg::S_TICK_DRAIN;
                end
            end
            pps_pkg::S_TICK_DRAIN:
            begin
                state_next = pps_pkg::S_TICK_FINISH;
            end
            pps_pkg::S_TICK_FINISH:
            begin
                state_next = pps_pkg::S_RESULT;
            end
            pps_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = pps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pps_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = new_job;
        ram_re        = 1'b0;
        load_out      = 1'b0;
        stat_req      = '0;
        stat_req.arrival = best_job_reg.arrival;
        stat_req.burst   = best_job_reg.burst;
        case (state_reg)
            pps_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            pps_pkg::S_ADD_SCAN:
            begin
                ram_we = slot_free;
            end
            pps_pkg::S_TICK_SCAN:
            begin
                ram_re = 1'b1;
            end
            pps_pkg::S_TICK_FINISH:
            begin
                // write back the decremented count of the chosen job
                ram_we            = found_reg;
                ram_waddr         = best_idx_reg;
                ram_wdata         = run_job;
                stat_req.advance  = 1'b1;
                stat_req.complete = job_complete;
            end
            pps_pkg::S_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pps_pkg::S_IDLE;
            idx_reg     <= '0;
            valid_reg   <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= ram_re;
            if (s_accept)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if ((state_reg == pps_pkg::S_ADD_SCAN || state_reg == pps_pkg::S_TICK_SCAN)
                    && !is_last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (state_reg == pps_pkg::S_ADD_SCAN && slot_free)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (stat_req.complete)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= idx_reg;
        if (s_accept)
        begin
            in_arrival_reg <= s_axis_tdata[15:0];
            in_burst_reg   <= s_axis_tdata[31:16];
            in_prio_reg    <= s_axis_tdata[39:32];
            res_status_reg <= pps_pkg::ST_ZERO_BURST;
            res_slot_reg   <= '0;
        end
        if (rd_better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_job_reg <= rd_job;
        end
        if (state_reg == pps_pkg::S_ADD_SCAN)
        begin
            if (slot_free)
            begin
                res_status_reg <= pps_pkg::ST_ADDED;
                res_slot_reg   <= idx_reg;
            end
            else if (is_last)
            begin
                res_status_reg <= pps_pkg::ST_FULL;
            end
        end
        if (state_reg == pps_pkg::S_TICK_FINISH)
        begin
            if (!found_reg)
            begin
                res_status_reg <= pps_pkg::ST_IDLE_TICK;
            end
            else
            begin
                res_status_reg <= job_complete ? pps_pkg::ST_DONE : pps_pkg::ST_RAN;
                res_slot_reg   <= best_idx_reg;
            end
        end
        if (load_out)
        begin
            out_tuser_reg <= res_status_reg;
            out_tdata_reg <= {4'd0, stat.jobs_done, stat.sum_waiting, stat.sum_turnaround,
                              res_done ? stat.waiting : 16'd0,
                              res_done ? stat.turnaround : 16'd0,
                              res_done ? stat.completion : 16'd0,
                              slot_ext[3:0]};
        end
    end

    // slot field carries the low bits of the index
    assign slot_ext = {4'd0, res_slot_reg};
    assign res_done = (res_status_reg == pps_pkg::ST_DONE);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tdata_reg;
    assign m_axis_tuser  = out_tuser_reg;

    a_add_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pps_pkg::S_ADD_SCAN && slot_free) |=> valid_reg[$past(idx_reg)])
        else $error("added slot not marked valid");

    a_done_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        stat_req.complete |=> !valid_reg[$past(best_idx_reg)])
        else $error("completed slot still valid");

    a_best_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg && (state_reg == pps_pkg::S_TICK_DRAIN
                       || state_reg == pps_pkg::S_TICK_FINISH)) |-> valid_reg[best_idx_reg])
        else $error("chosen job is in a free slot");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_axis_tready)
        else $error("second item taken while one is in work");

endmodule
